// ===== rtl/hrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request header parser package
// Result word layout, parser codes and character constants.
// ----------------------------------------------------------------------------
package hrp_pkg;

   localparam int LEN_W      = 21;
   localparam int MAX_RES    = 3;
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = 2;
   localparam int CNT_W      = 3;
   localparam int ACC_HI     = 1048575;
   localparam int ACC_LO     = -1048576;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_QMARK = 8'h3F;

   typedef enum logic [1:0] {KIND_PATH, KIND_QUERY, KIND_BODY, KIND_SUMMARY} kind_type;
   typedef enum logic [1:0] {METHOD_GET, METHOD_POST, METHOD_UNDEF} method_type;
   typedef enum logic [1:0] {
      DISP_SERVE, DISP_PROGRAM, DISP_BAD_REQUEST, DISP_NOT_IMPL
   } dispatch_type;
   typedef enum logic [2:0] {
      PH_IDLE, PH_LF0, PH_BLANK, PH_PATH, PH_QUERY, PH_BODY, PH_DONE
   } phase_type;
   typedef enum logic [1:0] {SCAN_SKIP, SCAN_POS, SCAN_NEG, SCAN_STOP} scan_type;

   typedef struct packed {
      kind_type          kind;
      logic [7:0]        data;
      method_type        method;
      dispatch_type      dispatch;
      logic [LEN_W-1:0]  length;
      logic              last;
   } result_type;

   function automatic logic [7:0] get_char(input logic [1:0] idx);
      logic [7:0] ch;
      case (idx)
         2'd0:    ch = "G";
         2'd1:    ch = "E";
         2'd2:    ch = "T";
         default: ch = CH_NUL;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] post_char(input logic [1:0] idx);
      logic [7:0] ch;
      case (idx)
         2'd0:    ch = "P";
         2'd1:    ch = "O";
         2'd2:    ch = "S";
         default: ch = "T";
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] len_char(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = "C";
         4'd1:    ch = "o";
         4'd2:    ch = "n";
         4'd3:    ch = "t";
         4'd4:    ch = "e";
         4'd5:    ch = "n";
         4'd6:    ch = "t";
         4'd7:    ch = "-";
         4'd8:    ch = "L";
         4'd9:    ch = "e";
         4'd10:   ch = "n";
         4'd11:   ch = "g";
         4'd12:   ch = "t";
         4'd13:   ch = "h";
         4'd14:   ch = ":";
         default: ch = CH_NUL;
      endcase
      return ch;
   endfunction

   function automatic logic in_header(input phase_type ph);
      return (ph == PH_IDLE) || (ph == PH_LF0) || (ph == PH_BLANK) ||
             (ph == PH_PATH) || (ph == PH_QUERY);
   endfunction

endpackage

// ===== rtl/hrp_rsp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result queue
// Takes up to MAX_RES words per cycle, drains one per cycle unless stalled.
// ----------------------------------------------------------------------------
module hrp_rsp_fifo import hrp_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [1:0]                  push_cnt,
   input  result_type [MAX_RES-1:0]    push_data,
   input  logic                        out_stall,
   output logic                        out_valid,
   output result_type                  out_data,
   output logic                        room
);

   result_type       mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pop;

   assign out_valid = (cnt_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && !out_stall;
   assign room      = (cnt_ff + CNT_W'(MAX_RES)) <= (CNT_W'(FIFO_DEPTH) + CNT_W'(pop));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      cnt_in    = cnt_ff + CNT_W'(push_cnt) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RES; i++) begin
         if (2'(i) < push_cnt) begin
            mem_ff[wr_ptr_ff + PTR_W'(i)] <= push_data[i];
         end
      end
   end

endmodule

// ===== rtl/hrp_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parser step
// Parser state and the per-byte update; yields up to MAX_RES result words.
// ----------------------------------------------------------------------------
module hrp_step import hrp_pkg::*; #(
   parameter int LINE_MAX  = 512,
   parameter int PATH_MAX  = 128,
   parameter int QUERY_MAX = 128
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [7:0]                  data_byte,
   input  logic                        stream_end,
   input  logic                        new_request,
   output logic [1:0]                  res_cnt,
   output result_type [MAX_RES-1:0]    res_data
);

   localparam int LP_W  = $clog2(LINE_MAX);
   localparam int NXT_W = LP_W + 1;
   localparam int PC_W  = $clog2(PATH_MAX + 1);
   localparam int QC_W  = $clog2(QUERY_MAX + 1);
   localparam int MUL_W = LEN_W + 4;

   typedef struct packed {
      logic [LP_W-1:0]  line_pos;
      logic             pend_cr;
      method_type       method;
      phase_type        phase;
      logic [2:0]       flags;
      logic [PC_W-1:0]  path_cnt;
      logic [QC_W-1:0]  query_cnt;
      logic [LEN_W-1:0] acc;
      scan_type         scan;
      logic [QC_W-1:0]  body_rem;
   } st_type;

   st_type st_ff, st_in;

   function automatic st_type line_start(input st_type si);
      st_type so;
      so          = si;
      so.line_pos = '0;
      so.flags    = 3'b111;
      so.scan     = SCAN_SKIP;
      so.phase    = PH_IDLE;
      return so;
   endfunction

   function automatic st_type clear_state();
      st_type so;
      so           = line_start('0);
      so.pend_cr   = 1'b0;
      so.method    = METHOD_UNDEF;
      so.path_cnt  = '0;
      so.query_cnt = '0;
      so.acc       = '0;
      so.body_rem  = '0;
      return so;
   endfunction

   function automatic void summarize(input st_type si, output st_type so,
                                     output result_type r);
      logic         body;
      dispatch_type disp;
      so   = si;
      body = (si.method == METHOD_POST) && ($signed(si.acc) > 0);
      case (si.method)
         METHOD_GET:  disp = DISP_SERVE;
         METHOD_POST: disp = (si.acc == '0) ? DISP_BAD_REQUEST : DISP_PROGRAM;
         default:     disp = DISP_NOT_IMPL;
      endcase
      if (body) begin
         so.body_rem = ($signed(si.acc) > QUERY_MAX) ? QC_W'(QUERY_MAX) : si.acc[QC_W-1:0];
      end
      r          = '0;
      r.kind     = KIND_SUMMARY;
      r.method   = si.method;
      r.dispatch = disp;
      r.length   = si.acc;
      r.last     = !body;
      so.line_pos = '0;
      so.phase    = body ? PH_BODY : PH_DONE;
   endfunction

   function automatic void line_done(input st_type si, output st_type so,
                                     output logic ev, output result_type r);
      st_type ts;
      ev = 1'b0;
      r  = '0;
      so = line_start(si);
      if (si.phase == PH_LF0 || si.phase == PH_BLANK) begin
         ev = 1'b1;
         summarize(si, ts, r);
         so = ts;
      end
   endfunction

   // atoi-style Content-Length digits, saturating
   function automatic st_type scan_digit(input st_type si, input logic [7:0] c);
      st_type                  so;
      logic                    ws, dig, go;
      logic signed [MUL_W-1:0] acc_x, dv_x, prod, n;
      so    = si;
      ws    = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
      dig   = (c >= CH_0) && (c <= CH_9);
      go    = 1'b0;
      acc_x = {{(MUL_W-LEN_W){si.acc[LEN_W-1]}}, si.acc};
      dv_x  = MUL_W'(c[3:0]);
      prod  = (acc_x <<< 3) + (acc_x <<< 1);
      case (si.scan)
         SCAN_SKIP: begin
            if (!ws) begin
               if (c == CH_PLUS) so.scan = SCAN_POS;
               else if (c == CH_MINUS) so.scan = SCAN_NEG;
               else if (!dig) so.scan = SCAN_STOP;
               else begin
                  so.scan = SCAN_POS;
                  go      = 1'b1;
               end
            end
         end
         SCAN_POS, SCAN_NEG: begin
            if (dig) go = 1'b1;
            else so.scan = SCAN_STOP;
         end
         default: so.scan = SCAN_STOP;
      endcase
      if (go) begin
         if (so.scan == SCAN_POS) begin
            n      = prod + dv_x;
            so.acc = (n > ACC_HI) ? LEN_W'(ACC_HI) : n[LEN_W-1:0];
         end else begin
            n      = prod - dv_x;
            so.acc = (n < ACC_LO) ? LEN_W'(ACC_LO) : n[LEN_W-1:0];
         end
      end
      return so;
   endfunction

   function automatic void feed(input st_type si, input logic [7:0] c, input logic term,
                                output st_type so, output logic ev, output result_type r);
      logic [LP_W-1:0]  pos;
      logic [NXT_W-1:0] nxt;
      logic             lev;
      result_type       lr;
      st_type           ls;
      so  = si;
      ev  = 1'b0;
      r   = '0;
      pos = si.line_pos;

      if (si.phase == PH_LF0) begin
         so.phase = (pos == LP_W'(1) && c == CH_NUL) ? PH_BLANK : PH_IDLE;
      end else if (si.phase == PH_IDLE && pos == '0 && c == CH_LF) begin
         so.phase = PH_LF0;
      end

      if (pos < LP_W'(3) && (si.method != METHOD_UNDEF || c != get_char(pos[1:0])))
         so.flags[0] = 1'b0;
      if (pos < LP_W'(4) && (si.method != METHOD_UNDEF || c != post_char(pos[1:0])))
         so.flags[1] = 1'b0;
      if (pos < LP_W'(15) && (si.method != METHOD_POST || c != len_char(pos[3:0])))
         so.flags[2] = 1'b0;

      if (pos == LP_W'(2) && so.flags[0]) begin
         so.method   = METHOD_GET;
         so.phase    = PH_PATH;
         so.path_cnt = PC_W'(1);
         ev          = 1'b1;
         r.kind      = KIND_PATH;
         r.data      = CH_DOT;
      end else if (pos == LP_W'(3) && so.flags[1]) begin
         so.method   = METHOD_POST;
         so.phase    = PH_PATH;
         so.path_cnt = PC_W'(1);
         ev          = 1'b1;
         r.kind      = KIND_PATH;
         r.data      = CH_DOT;
      end else if (so.phase == PH_PATH &&
                   pos >= ((so.method == METHOD_GET) ? LP_W'(4) : LP_W'(5))) begin
         if (so.path_cnt >= PC_W'(PATH_MAX) || c == CH_NUL || c == CH_SPACE) begin
            so.phase = PH_IDLE;
         end else if (c == CH_QMARK) begin
            so.phase     = PH_QUERY;
            so.query_cnt = '0;
         end else begin
            ev          = 1'b1;
            r.kind      = KIND_PATH;
            r.data      = c;
            so.path_cnt = so.path_cnt + PC_W'(1);
         end
      end else if (so.phase == PH_QUERY) begin
         if (so.query_cnt >= QC_W'(QUERY_MAX) || c == CH_NUL || c == CH_SPACE) begin
            so.phase = PH_IDLE;
         end else begin
            ev           = 1'b1;
            r.kind       = KIND_QUERY;
            r.data       = c;
            so.query_cnt = so.query_cnt + QC_W'(1);
         end
      end

      if (so.flags[2]) begin
         if (pos == LP_W'(14)) begin
            so.acc  = '0;
            so.scan = SCAN_SKIP;
         end else if (pos >= LP_W'(15)) begin
            so = scan_digit(so, c);
         end
      end

      nxt = {1'b0, pos} + NXT_W'(1);
      if (term || nxt >= NXT_W'(LINE_MAX)) begin
         line_done(so, ls, lev, lr);
         so = ls;
         if (lev) begin
            ev = 1'b1;
            r  = lr;
         end
      end else begin
         so.line_pos = nxt[LP_W-1:0];
      end
   endfunction

   function automatic void body_byte(input st_type si, input logic [7:0] c,
                                     output st_type so, output logic ev,
                                     output result_type r);
      so = si;
      ev = 1'b0;
      r  = '0;
      if (si.body_rem == '0) begin
         so.phase = PH_DONE;
      end else begin
         so.body_rem = si.body_rem - QC_W'(1);
         ev          = 1'b1;
         r.kind      = KIND_BODY;
         r.data      = c;
         r.last      = (so.body_rem == '0);
         if (so.body_rem == '0) so.phase = PH_DONE;
      end
   endfunction

   always_comb begin
      st_type                   s, ts;
      logic [1:0]               n;
      result_type [MAX_RES-1:0] res;
      logic                     ev, go_on;
      result_type               er;
      s     = st_ff;
      ts    = st_ff;
      n     = '0;
      res   = '0;
      ev    = 1'b0;
      er    = '0;
      go_on = 1'b1;

      if (new_request) s = clear_state();

      if (stream_end) begin
         if (s.phase == PH_BODY) begin
            s.phase = PH_DONE;
         end else if (in_header(s.phase)) begin
            if (s.pend_cr) begin
               s.pend_cr = 1'b0;
               feed(s, CH_CR, 1'b0, ts, ev, er);
               s = ts;
               if (ev) begin
                  res[n] = er;
                  n      = n + 2'd1;
               end
            end
            if (in_header(s.phase) && s.line_pos != '0) begin
               line_done(s, ts, ev, er);
               s = ts;
               if (ev) begin
                  res[n] = er;
                  n      = n + 2'd1;
               end
            end
            if (in_header(s.phase)) begin
               summarize(s, ts, er);
               s      = ts;
               res[n] = er;
               n      = n + 2'd1;
            end
            if (s.phase == PH_BODY) s.phase = PH_DONE;
         end
      end else if (s.phase == PH_BODY) begin
         body_byte(s, data_byte, ts, ev, er);
         s = ts;
         if (ev) begin
            res[n] = er;
            n      = n + 2'd1;
         end
      end else if (in_header(s.phase)) begin
         // held CR: CR LF ends the line as LF, otherwise the CR is data
         if (s.pend_cr) begin
            s.pend_cr = 1'b0;
            if (data_byte == CH_LF) begin
               feed(s, CH_LF, 1'b1, ts, ev, er);
               go_on = 1'b0;
            end else begin
               feed(s, CH_CR, 1'b0, ts, ev, er);
            end
            s = ts;
            if (ev) begin
               res[n] = er;
               n      = n + 2'd1;
            end
            if (go_on && !in_header(s.phase)) begin
               go_on = 1'b0;
               if (s.phase == PH_BODY) begin
                  body_byte(s, data_byte, ts, ev, er);
                  s = ts;
                  if (ev) begin
                     res[n] = er;
                     n      = n + 2'd1;
                  end
               end
            end
         end
         if (go_on) begin
            if (data_byte == CH_CR) begin
               s.pend_cr = 1'b1;
            end else begin
               feed(s, data_byte, 1'b0, ts, ev, er);
               s = ts;
               if (ev) begin
                  res[n] = er;
                  n      = n + 2'd1;
               end
            end
         end
      end

      st_in    = step ? s : st_ff;
      res_cnt  = n;
      res_data = res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= clear_state();
      end else begin
         st_ff <= st_in;
      end
   end

endmodule

// ===== rtl/http_request_header_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request header parser
// Byte-wide HTTP/1.0 request parser: path, query, header summary, POST body.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one request byte per word, with stream_end to
//   flush and finish a request and new_request to clear the parser first.
//   The rsp_ channel carries path, query and body bytes and one summary word
//   per request (method, dispatch code, Content-Length); last marks the final
//   word of a request.
//   A word is taken at a clock edge with valid high and stall low.
//   A result passes the input register and the result queue before it is taken.
//   Throughput: one byte per cycle; the parser steps only while the four-word
//   result queue has room for three words, which is what req_stall reflects.
//   A single byte can give up to three result words, drained one per cycle
//   while rsp_stall is low. When rsp_stall is held, the queue fills and
//   req_stall rises; nothing is lost or reordered.
//   Reset (synchronous) empties the input stage and the result queue and puts
//   the parser at the start of a request with the method undefined.
// ----------------------------------------------------------------------------
module http_request_header_parser import hrp_pkg::*; #(
   parameter int LINE_MAX  = 512,
   parameter int PATH_MAX  = 128,
   parameter int QUERY_MAX = 128
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_stream_end,
   input  logic                    req_new_request,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_kind,
   output logic [7:0]              rsp_byte_out,
   output logic [1:0]              rsp_method,
   output logic [1:0]              rsp_dispatch,
   output logic signed [LEN_W-1:0] rsp_content_length,
   output logic                    rsp_last
);

   logic                     in_vld_ff, in_vld_in;
   logic [7:0]               in_byte_ff;
   logic                     in_end_ff;
   logic                     in_new_ff;
   logic                     accept, step, room;
   logic [1:0]               res_cnt, push_cnt;
   result_type [MAX_RES-1:0] res_data;
   result_type               head;

   assign step      = in_vld_ff && room;
   assign req_stall = in_vld_ff && !room;
   assign accept    = req_valid && !req_stall;
   assign in_vld_in = accept || (in_vld_ff && !room);
   assign push_cnt  = step ? res_cnt : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_data_byte;
         in_end_ff  <= req_stream_end;
         in_new_ff  <= req_new_request;
      end
   end

   hrp_step #(
      .LINE_MAX  (LINE_MAX),
      .PATH_MAX  (PATH_MAX),
      .QUERY_MAX (QUERY_MAX)
   ) u_step (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .data_byte   (in_byte_ff),
      .stream_end  (in_end_ff),
      .new_request (in_new_ff),
      .res_cnt     (res_cnt),
      .res_data    (res_data)
   );

   hrp_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push_data (res_data),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (head),
      .room      (room)
   );

   assign rsp_kind           = head.kind;
   assign rsp_byte_out       = head.data;
   assign rsp_method         = head.method;
   assign rsp_dispatch       = head.dispatch;
   assign rsp_content_length = $signed(head.length);
   assign rsp_last           = head.last;

endmodule

// ===== bench/tb_http_request_header_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request header parser testbench
// Feeds request byte streams (directed requests, random well-formed and
// broken requests with plain and saturating lengths and short bodies) under
// four traffic patterns. A scoreboard predicts every path, query, body and
// summary word and checks the result channel against it in order.
// ----------------------------------------------------------------------------
module tb_http_request_header_parser import hrp_pkg::*; ();

   localparam int LINE_MAX  = 512;
   localparam int PATH_MAX  = 128;
   localparam int QUERY_MAX = 128;

   typedef struct {
      logic [7:0] byte_val;
      logic       close;
      logic       restart;
   } req_word_type;

   class parser_scoreboard #(int LINE_LIM = 512, int PATH_LIM = 128, int QUERY_LIM = 128);

      int unsigned  col;
      bit           cr_held;
      method_type   meth;
      phase_type    phase;
      bit [2:0]     match;
      int unsigned  path_n;
      int unsigned  query_n;
      int unsigned  body_left;
      int           len_acc;
      scan_type     scan;
      int           step_n;

      string tok_get  = "GET";
      string tok_post = "POST";
      string tok_len  = "Content-Length:";

      result_type   pending_results[$];
      int unsigned  words_seen;
      int unsigned  results_seen;
      int unsigned  summaries_seen;
      int unsigned  mismatches;

      function new();
         clear();
      endfunction

      function void new_line();
         col   = 0;
         match = 3'b111;
         scan  = SCAN_SKIP;
         phase = PH_IDLE;
      endfunction

      function void clear();
         new_line();
         cr_held   = 1'b0;
         meth      = METHOD_UNDEF;
         path_n    = 0;
         query_n   = 0;
         len_acc   = 0;
         body_left = 0;
      endfunction

      function bit in_headers();
         return phase <= PH_QUERY;
      endfunction

      function void push(kind_type k, logic [7:0] b, method_type m, dispatch_type d, int len,
                         bit last);
         result_type r;
         if (step_n >= MAX_RES) return;
         r.kind     = k;
         r.data     = b;
         r.method   = m;
         r.dispatch = d;
         r.length   = len[LEN_W-1:0];
         r.last     = last;
         pending_results.push_back(r);
         step_n++;
      endfunction

      // path, query and body words carry zero in the summary fields
      function void push_data(kind_type k, logic [7:0] b, bit last);
         push(k, b, METHOD_GET, DISP_SERVE, 0, last);
      endfunction

      function void emit_summary();
         dispatch_type d;
         bit           body;
         body = 1'b0;
         case (meth)
            METHOD_GET:  d = DISP_SERVE;
            METHOD_POST: d = (len_acc == 0) ? DISP_BAD_REQUEST : DISP_PROGRAM;
            default:     d = DISP_NOT_IMPL;
         endcase
         if (meth == METHOD_POST && len_acc > 0) begin
            body      = 1'b1;
            body_left = (len_acc > QUERY_LIM) ? QUERY_LIM : len_acc;
         end
         push(KIND_SUMMARY, CH_NUL, meth, d, len_acc, !body);
         col   = 0;
         phase = body ? PH_BODY : PH_DONE;
      endfunction

      function void end_of_line();
         if (phase == PH_LF0 || phase == PH_BLANK) emit_summary();
         else new_line();
      endfunction

      function void scan_length(logic [7:0] c);
         bit ws;
         bit dig;
         int d;
         int n;
         ws  = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
         dig = (c >= CH_0) && (c <= CH_9);
         d   = int'(c) - int'(CH_0);
         if (scan == SCAN_SKIP) begin
            if (ws) return;
            if (c == CH_PLUS) begin
               scan = SCAN_POS;
               return;
            end
            if (c == CH_MINUS) begin
               scan = SCAN_NEG;
               return;
            end
            if (!dig) begin
               scan = SCAN_STOP;
               return;
            end
            scan = SCAN_POS;
         end else if (scan == SCAN_STOP || !dig) begin
            scan = SCAN_STOP;
            return;
         end
         if (scan == SCAN_POS) begin
            n       = len_acc * 10 + d;
            len_acc = (n > ACC_HI) ? ACC_HI : n;
         end else begin
            n       = len_acc * 10 - d;
            len_acc = (n < ACC_LO) ? ACC_LO : n;
         end
      endfunction

      function void line_byte(logic [7:0] c, bit term);
         int unsigned p;
         p = col;
         if (phase == PH_LF0) phase = (p == 1 && c == CH_NUL) ? PH_BLANK : PH_IDLE;
         else if (phase == PH_IDLE && p == 0 && c == CH_LF) phase = PH_LF0;

         if (p < 3 && (meth != METHOD_UNDEF || c != tok_get[p])) match[0] = 1'b0;
         if (p < 4 && (meth != METHOD_UNDEF || c != tok_post[p])) match[1] = 1'b0;
         if (p < 15 && (meth != METHOD_POST || c != tok_len[p])) match[2] = 1'b0;

         if (p == 2 && match[0]) begin
            meth   = METHOD_GET;
            phase  = PH_PATH;
            path_n = 1;
            push_data(KIND_PATH, CH_DOT, 1'b0);
         end else if (p == 3 && match[1]) begin
            meth   = METHOD_POST;
            phase  = PH_PATH;
            path_n = 1;
            push_data(KIND_PATH, CH_DOT, 1'b0);
         end else if (phase == PH_PATH && p >= ((meth == METHOD_GET) ? 4 : 5)) begin
            if (path_n >= PATH_LIM || c == CH_NUL || c == CH_SPACE) begin
               phase = PH_IDLE;
            end else if (c == CH_QMARK) begin
               phase   = PH_QUERY;
               query_n = 0;
            end else begin
               push_data(KIND_PATH, c, 1'b0);
               path_n++;
            end
         end else if (phase == PH_QUERY) begin
            if (query_n >= QUERY_LIM || c == CH_NUL || c == CH_SPACE) begin
               phase = PH_IDLE;
            end else begin
               push_data(KIND_QUERY, c, 1'b0);
               query_n++;
            end
         end

         if (match[2]) begin
            if (p == 14) begin
               len_acc = 0;
               scan    = SCAN_SKIP;
            end else if (p >= 15) begin
               scan_length(c);
            end
         end

         col = p + 1;
         if (term || col >= LINE_LIM) end_of_line();
      endfunction

      function void body_byte(logic [7:0] c);
         if (body_left == 0) begin
            phase = PH_DONE;
            return;
         end
         body_left--;
         push_data(KIND_BODY, c, body_left == 0);
         if (body_left == 0) phase = PH_DONE;
      endfunction

      function void take_byte(logic [7:0] c);
         if (phase == PH_BODY) begin
            body_byte(c);
            return;
         end
         if (!in_headers()) return;
         if (cr_held) begin
            cr_held = 1'b0;
            if (c == CH_LF) begin
               line_byte(CH_LF, 1'b1);
               return;
            end
            line_byte(CH_CR, 1'b0);
            if (!in_headers()) begin
               if (phase == PH_BODY) body_byte(c);
               return;
            end
         end
         if (c == CH_CR) begin
            cr_held = 1'b1;
            return;
         end
         line_byte(c, 1'b0);
      endfunction

      function void close_stream();
         if (phase == PH_BODY) begin
            phase = PH_DONE;
            return;
         end
         if (!in_headers()) return;
         if (cr_held) begin
            cr_held = 1'b0;
            line_byte(CH_CR, 1'b0);
         end
         if (in_headers() && col > 0) end_of_line();
         if (in_headers()) emit_summary();
         if (phase == PH_BODY) phase = PH_DONE;
      endfunction

      function void note_word(logic [7:0] data, logic close, logic restart);
         step_n = 0;
         words_seen++;
         if (restart) clear();
         if (close) close_stream();
         else take_byte(data);
      endfunction

      function void check_result(logic [1:0] k, logic [7:0] b, logic [1:0] m, logic [1:0] d,
                                 logic [LEN_W-1:0] len, logic last);
         result_type got;
         result_type want;
         bit         bad;
         got.kind     = kind_type'(k);
         got.data     = b;
         got.method   = method_type'(m);
         got.dispatch = dispatch_type'(d);
         got.length   = len;
         got.last     = last;
         results_seen++;
         if (got.kind == KIND_SUMMARY) summaries_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: extra word kind %0d byte %h meth %0d disp %0d len %0d last %0d",
                        $time, got.kind, got.data, got.method, got.dispatch,
                        $signed(got.length), got.last);
            return;
         end
         want = pending_results.pop_front();
         bad  = (got.kind !== want.kind) || (got.data !== want.data) ||
                (got.method !== want.method) || (got.dispatch !== want.dispatch) ||
                (got.length !== want.length) || (got.last !== want.last);
         if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: expected kind %0d byte %h meth %0d disp %0d len %0d last %0d",
                        $time, want.kind, want.data, want.method, want.dispatch,
                        $signed(want.length), want.last);
               $display("%0t:      got kind %0d byte %h meth %0d disp %0d len %0d last %0d",
                        $time, got.kind, got.data, got.method, got.dispatch,
                        $signed(got.length), got.last);
            end
         end
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [7:0]              req_data_byte = 8'h00;
   logic                    req_stream_end = 1'b0;
   logic                    req_new_request = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [1:0]              rsp_kind;
   logic [7:0]              rsp_byte_out;
   logic [1:0]              rsp_method;
   logic [1:0]              rsp_dispatch;
   logic signed [LEN_W-1:0] rsp_content_length;
   logic                    rsp_last;

   parser_scoreboard #(LINE_MAX, PATH_MAX, QUERY_MAX) sb;

   req_word_type plan[$];
   int          tx_idle_pct  = 0;
   int          rx_stall_pct = 0;
   int          tx_calm      = 0;
   int          rx_calm      = 0;
   int unsigned requests_sent = 0;
   int          tx_idle_set[4]  = '{0, 86, 0, 35};
   int          rx_stall_set[4] = '{0, 0, 86, 35};

   http_request_header_parser #(
      .LINE_MAX  (LINE_MAX),
      .PATH_MAX  (PATH_MAX),
      .QUERY_MAX (QUERY_MAX)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_stream_end     (req_stream_end),
      .req_new_request    (req_new_request),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_byte_out       (rsp_byte_out),
      .rsp_method         (rsp_method),
      .rsp_dispatch       (rsp_dispatch),
      .rsp_content_length (rsp_content_length),
      .rsp_last           (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_word(req_data_byte, req_stream_end, req_new_request);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_kind, rsp_byte_out, rsp_method, rsp_dispatch,
                            rsp_content_length, rsp_last);
      end
   end

   always @(negedge clock) begin
      if (rx_calm > 0) rx_calm--;
      else if ($urandom_range(49) == 0) rx_calm = $urandom_range(10, 40);
      rsp_stall <= (rx_calm == 0) && ($urandom_range(99) < rx_stall_pct);
   end

   function automatic void put(logic [7:0] b);
      req_word_type w;
      w.byte_val = b;
      w.close    = 1'b0;
      w.restart  = 1'b0;
      plan.push_back(w);
   endfunction

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) put(s[i]);
   endfunction

   function automatic void put_eol();
      put(CH_CR);
      put(CH_LF);
   endfunction

   function automatic void put_close();
      req_word_type w;
      w.byte_val = 8'($urandom);
      w.close    = 1'b1;
      w.restart  = 1'b0;
      plan.push_back(w);
   endfunction

   function automatic logic [7:0] path_char();
      string pool = "abz/._-~09";
      if ($urandom_range(11) == 0) return 8'($urandom);
      return pool[$urandom_range(pool.len() - 1)];
   endfunction

   function automatic int put_number();
      int v;
      int pick;
      repeat ($urandom_range(2)) put($urandom_range(1) ? CH_SPACE : CH_TAB);
      pick = $urandom_range(9);
      if (pick < 5) v = $urandom_range(7);
      else if (pick < 7) v = $urandom_range(2000000, 100);
      else if (pick < 9) v = -int'($urandom_range(2000000, 1));
      else return 0;
      if (v >= 0 && $urandom_range(4) == 0) put(CH_PLUS);
      put_text($sformatf("%0d", v));
      if ($urandom_range(5) == 0) put(path_char());
      return v;
   endfunction

   // one random request into plan; returns its word count
   function automatic int build_request();
      int v;
      int n;
      bit is_post;
      plan.delete();
      v       = 0;
      is_post = 1'b0;
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(12, 1)) put(8'($urandom));
         if ($urandom_range(1)) put_close();
      end else begin
         if ($urandom_range(9) == 0) begin
            put_text("Host: h");
            put_eol();
         end
         n = $urandom_range(99);
         if (n < 45) begin
            put_text("GET");
         end else if (n < 85) begin
            put_text("POST");
            is_post = 1'b1;
         end else begin
            case ($urandom_range(3))
               0:       put_text("PUT");
               1:       put_text("GEX");
               2:       put_text("POS");
               default: put_text(" GET");
            endcase
         end
         put(($urandom_range(9) == 0) ? path_char() : CH_SPACE);
         put("/");
         repeat ($urandom_range(4)) put(path_char());
         if ($urandom_range(1)) begin
            put(CH_QMARK);
            repeat ($urandom_range(3)) put(path_char());
         end
         if ($urandom_range(1)) put_text(" HTTP/1.0");
         case ($urandom_range(19))
            0: put(CH_LF);
            1: begin
               put(CH_CR);
               put(path_char());
               put_eol();
            end
            default: put_eol();
         endcase
         repeat ($urandom_range(2)) begin
            if ($urandom_range(9) < 6) begin
               put_text("Content-Length:");
               v = put_number();
            end else if ($urandom_range(1)) begin
               put_text("Content-Lengtx: 5");
            end else begin
               put_text("Ab: c");
            end
            put_eol();
         end
         case ($urandom_range(9))
            0: put_close();
            1: begin
               put(CH_CR);
               put_close();
            end
            2: begin
               put(CH_LF);
               put(CH_NUL);
               put_eol();
            end
            default: put_eol();
         endcase
         if (is_post) begin
            n = (v > 0 && v < 8) ? v : $urandom_range(4);
            repeat (n) put(8'($urandom));
            if ($urandom_range(3) == 0) put_close();
         end
      end
      if ($urandom_range(4) == 0) repeat ($urandom_range(3, 1)) put(8'($urandom));
      return plan.size();
   endfunction

   task automatic send_word(input req_word_type w);
      if (tx_calm > 0) tx_calm--;
      else if ($urandom_range(49) == 0) tx_calm = $urandom_range(10, 40);
      while (tx_calm == 0 && $urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= w.byte_val;
      req_stream_end  <= w.close;
      req_new_request <= w.restart;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic run_plan();
      plan[0].restart = 1'b1;
      foreach (plan[i]) send_word(plan[i]);
      requests_sent++;
   endtask

   task automatic directed_requests();
      plan.delete();
      put_text("GET /?z");
      put_eol();
      put_eol();
      run_plan();
      plan.delete();
      put_text("POST /");
      put_close();
      run_plan();
      // blank line given as LF then a zero byte, no method
      plan.delete();
      put(CH_LF);
      put(CH_NUL);
      put_close();
      run_plan();
      plan.delete();
      put(8'hFF);
      put_close();
      run_plan();
   endtask

   initial begin
      int words;
      int waited;
      sb = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int ph = 0; ph < 4; ph++) begin
         tx_idle_pct  = tx_idle_set[ph];
         rx_stall_pct = rx_stall_set[ph];
         if (ph == 0) directed_requests();
         words = 0;
         while (words < 24) begin
            words += build_request();
            run_plan();
         end
      end
      req_valid <= 1'b0;
      waited = 0;
      while (sb.pending() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (sb.pending() != 0) begin
         $display("%0d expected result words never arrived", sb.pending());
         sb.mismatches += sb.pending();
      end
      $display("covered %0d requests, %0d input words, %0d result words (%0d summaries)",
               requests_sent, sb.words_seen, sb.results_seen, sb.summaries_seen);
      $display("four traffic patterns: free flow, idle sender, stalling receiver, both; %0d bad",
               sb.mismatches);
      if (sb.mismatches == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   initial begin
      #12000000;
      $display("simulation failed");
      $finish;
   end

endmodule
